/* rtl/rgbce_pkg.sv */
package rgbce_pkg;

  localparam int unsigned RED_W   = 5;
  localparam int unsigned GREEN_W = 6;
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 32;
  localparam int unsigned BRIGHT_W   = 6;
  localparam int unsigned CONTRAST_W = 9;
  localparam int unsigned CK_W       = 23;

  localparam logic [5:0] RED_MAX   = 6'd31;
  localparam logic [5:0] GREEN_MAX = 6'd63;
  localparam logic [5:0] RED_MID   = 6'd16;
  localparam logic [5:0] GREEN_MID = 6'd32;
  localparam logic [5:0] FROZEN_RED_DROP   = 6'd12;
  localparam logic [5:0] FROZEN_GREEN_DROP = 6'd24;
  localparam logic [5:0] FROZEN_BLUE_LIFT  = 6'd24;
  localparam logic [5:0] LIGHT_LIFT        = 6'd4;
  localparam logic [5:0] TOXIC_GREEN_MIN   = 6'd8;
  localparam logic [5:0] BERSERK_RED_MIN   = 6'd4;

  localparam logic [CONTRAST_W-1:0] CONTRAST_RESET = 9'd100;

  // Division by 100 is a multiply by 5243 and a shift by 19, with a bias that keeps the
  // floor exact for every product of a channel offset and a 9-bit contrast.
  localparam logic [13:0] RECIP_100   = 14'd5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [29:0] RECIP_BIAS  = 30'd2048;

  localparam logic [CK_W-1:0] CK_RESET = 23'd524300;

  localparam logic CFG_IDX_BRIGHTNESS = 1'b0;
  localparam logic CFG_IDX_CONTRAST   = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PASS    = 3'd0,
    KIND_LIGHT   = 3'd1,
    KIND_FROZEN  = 3'd2,
    KIND_TOXIC   = 3'd3,
    KIND_BERSERK = 3'd4,
    KIND_BC      = 3'd5
  } kind_t;

endpackage

/* rtl/rgb565_color_effect_unit_top.sv */
// RGB565 color effect unit. Each input transaction carries one palette color (red in
// bits 4:0, green in bits 10:5, blue in bits 15:11 of in_tdata) and an effect kind in
// in_tuser; each output transaction carries the recolored channels in the same layout.
// Kinds: 0 pass, 1 light, 2 frozen, 3 toxic, 4 berserk, 5 brightness and contrast;
// kinds 6 and 7 pass the color through. The block takes one transaction per cycle when
// the output is not stalled, through an input register, one pass of logic built around a
// 7 by 24 bit multiplier per channel, and an output register. Brightness (address 0,
// signed 6 bits) and contrast in percent (address 4, 9 bits) must be written over the
// APB port only while no transaction is in flight; the block itself does not enforce this.
module rgb565_color_effect_unit_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: red_in[4:0], green_in[10:5], blue_in[15:11].
  input  logic [rgbce_pkg::DATA_W-1:0]      in_tdata,
  // Fields from bit 0: kind[2:0].
  input  logic [rgbce_pkg::KIND_W-1:0]      in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0: red_out[4:0], green_out[10:5], blue_out[15:11].
  output logic [rgbce_pkg::DATA_W-1:0]      out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [rgbce_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [rgbce_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [rgbce_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                              cfg_pready
);
  import rgbce_pkg::*;

  logic signed [BRIGHT_W-1:0] bright_r;
  logic [CONTRAST_W-1:0]      contrast_r;
  logic [CK_W-1:0]            ck_r;
  logic                       cfg_wr;

  logic                       s1_valid_r;
  logic [DATA_W-1:0]          s1_data_r;
  logic [KIND_W-1:0]          s1_kind_r;
  logic                       s1_adv;
  logic                       out_valid_r;
  logic [DATA_W-1:0]          out_data_r;
  logic [DATA_W-1:0]          out_data_nxt;
  logic                       out_load_ok;

  function automatic logic [5:0] bc_adjust(input logic [5:0] ch, input logic [5:0] mid,
                                           input logic signed [6:0] off,
                                           input logic [CK_W-1:0] ck,
                                           input logic [5:0] hi);
    logic signed [6:0]  d;
    logic signed [29:0] prod;
    logic signed [10:0] q;
    logic signed [11:0] sum;
    d    = $signed({1'b0, ch}) - $signed({1'b0, mid});
    prod = d * $signed({1'b0, ck});
    prod = prod + $signed(RECIP_BIAS);
    q    = prod[RECIP_SHIFT+10:RECIP_SHIFT];
    sum  = $signed({q[10], q}) + $signed({6'b0, mid}) + $signed({{5{off[6]}}, off});
    if (sum < 12'sd0) begin
      return 6'd0;
    end else if (sum > $signed({6'b0, hi})) begin
      return hi;
    end else begin
      return sum[5:0];
    end
  endfunction

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r   <= '0;
      contrast_r <= CONTRAST_RESET;
      ck_r       <= CK_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        CFG_IDX_BRIGHTNESS: bright_r <= cfg_pwdata[BRIGHT_W-1:0];
        CFG_IDX_CONTRAST: begin
          contrast_r <= cfg_pwdata[CONTRAST_W-1:0];
          ck_r       <= CK_W'(cfg_pwdata[CONTRAST_W-1:0]) * CK_W'(RECIP_100);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      CFG_IDX_BRIGHTNESS: cfg_prdata = {{(CFG_DW-BRIGHT_W){1'b0}}, bright_r};
      CFG_IDX_CONTRAST:   cfg_prdata = {{(CFG_DW-CONTRAST_W){1'b0}}, contrast_r};
      default:            cfg_prdata = '0;
    endcase
  end

  assign out_load_ok = !out_valid_r || out_tready;
  assign s1_adv      = s1_valid_r && out_load_ok;
  assign in_tready   = !s1_valid_r || out_load_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r <= in_tdata;
      s1_kind_r <= in_tuser;
    end
  end

  always_comb begin
    logic [5:0] r;
    logic [5:0] g;
    logic [5:0] b;
    logic [5:0] r_sum;
    logic [6:0] g_sum;
    logic [5:0] b_sum;
    logic signed [6:0] off_rb;
    logic signed [6:0] off_g;
    r_sum  = '0;
    g_sum  = '0;
    b_sum  = '0;
    r      = {1'b0, s1_data_r[4:0]};
    g      = s1_data_r[10:5];
    b      = {1'b0, s1_data_r[15:11]};
    off_rb = {bright_r[BRIGHT_W-1], bright_r};
    off_g  = {bright_r, 1'b0};
    case (kind_t'(s1_kind_r))
      KIND_LIGHT: begin
        r_sum = r + LIGHT_LIFT;
        g_sum = {1'b0, g} + {LIGHT_LIFT, 1'b0};
        b_sum = b + LIGHT_LIFT;
        r = (r_sum > RED_MAX) ? RED_MAX : r_sum;
        g = g_sum[6] ? GREEN_MAX : g_sum[5:0];
        b = (b_sum > RED_MAX) ? RED_MAX : b_sum;
      end
      KIND_FROZEN: begin
        b_sum = b + FROZEN_BLUE_LIFT;
        r = (r < FROZEN_RED_DROP) ? 6'd0 : r - FROZEN_RED_DROP;
        g = (g < FROZEN_GREEN_DROP) ? 6'd0 : g - FROZEN_GREEN_DROP;
        b = (b_sum > RED_MAX) ? RED_MAX : b_sum;
      end
      KIND_TOXIC: begin
        r = 6'd0;
        g = (g < TOXIC_GREEN_MIN) ? TOXIC_GREEN_MIN : g;
        b = 6'd0;
      end
      KIND_BERSERK: begin
        r = (r < BERSERK_RED_MIN) ? BERSERK_RED_MIN : r;
        g = 6'd0;
        b = 6'd0;
      end
      KIND_BC: begin
        r = bc_adjust(r, RED_MID, off_rb, ck_r, RED_MAX);
        g = bc_adjust(g, GREEN_MID, off_g, ck_r, GREEN_MAX);
        b = bc_adjust(b, RED_MID, off_rb, ck_r, RED_MAX);
      end
      default: ;
    endcase
    out_data_nxt = {b[RED_W-1:0], g[GREEN_W-1:0], r[RED_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load_ok) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* rtl/rgbce_checker.sv */
module rgbce_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [rgbce_pkg::DATA_W-1:0]      in_tdata,
  input logic [rgbce_pkg::KIND_W-1:0]      in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [rgbce_pkg::DATA_W-1:0]      out_tdata,
  input logic                              cfg_psel,
  input logic                              cfg_penable,
  input logic                              cfg_pwrite,
  input logic [rgbce_pkg::CFG_AW-1:0]      cfg_paddr,
  input logic [rgbce_pkg::CFG_DW-1:0]      cfg_pwdata,
  input logic [rgbce_pkg::CFG_DW-1:0]      cfg_prdata,
  input logic                              cfg_pready
);
  import rgbce_pkg::*;

  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // A stalled result keeps its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // A free output side never stalls the input side.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled with output ready");

  // An accepted transaction reaches the output via both registers when not stalled.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("result missing after accepted transaction");

  // A configuration write is read back at once.
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr ##1 (cfg_paddr[2] == $past(cfg_paddr[2])) |->
      (cfg_paddr[2] ? (cfg_prdata[CONTRAST_W-1:0] == $past(cfg_pwdata[CONTRAST_W-1:0]))
                    : (cfg_prdata[BRIGHT_W-1:0] == $past(cfg_pwdata[BRIGHT_W-1:0]))))
    else $error("configuration readback mismatch");

endmodule

bind rgb565_color_effect_unit_top rgbce_checker u_rgbce_checker (.*);
